### sv/bha_pkg.sv
// ----------------------------------------------------------------------------
// bha_pkg: shared types and constants for the break heap allocator
// Widths, modes, status codes and the command record passed front to back.
// ----------------------------------------------------------------------------
`default_nettype none
package bha_pkg;
  localparam int unsigned MaxBlocks   = 64;
  localparam int unsigned HeapBytes   = 1048576;
  localparam int unsigned HeaderBytes = 24;
  localparam int unsigned AlignBytes  = 16;
  localparam int unsigned DataW       = 21;
  localparam int unsigned IdxW        = $clog2(MaxBlocks);
  localparam int unsigned CntW        = IdxW + 1;
  localparam int unsigned QDepth      = 2;

  typedef logic [DataW-1:0] word_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [CntW-1:0]  cnt_t;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_ADDR = 2'd2
  } status_e;

  // Command classified by the front end.
  typedef struct packed {
    mode_e mode;
    logic  fail;   // immediate failure (zero size, oversize or bad mode)
    word_t size;   // rounded request
    word_t addr;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_COMMIT, S_POP, S_DONE
  } state_e;
endpackage
`default_nettype wire

### sv/break_heap_allocator.sv
// ----------------------------------------------------------------------------
// break_heap_allocator: table-based heap allocator with break pointer
// Allocate, free and size query against a 64-entry block table.
// ----------------------------------------------------------------------------
// Usage: drive valid_i with mode/req_bytes/address; a transaction is taken when
// valid_i is high and stall_o low. Each one gives a single result on valid_o
// with status, data_address and block_bytes, held until stall_i is low.
// heap_limit is written through cfg_we_i/cfg_wdata_i; the user must do so only while
// nothing is in flight, as the block itself does not enforce it. A request rejected
// up front (zero or oversize request, bad mode) skips the table walk. Otherwise the
// table walk reads one entry per cycle through the registered table RAM, and a free
// that hits then adds a tail check and pops free tail blocks one per cycle. One item
// is processed at a time; a two-entry command queue lets the sender keep going while
// the engine works.
// Reset clears the table count, the break and the queue; heap_limit returns
// to 1048576. A stalled result holds the engine until it is taken; the queue
// then fills and stall_o rises.
// ----------------------------------------------------------------------------
`default_nettype none
module break_heap_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [20:0] cfg_wdata_i,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [20:0] req_bytes_i,
  input  wire logic [20:0] address_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [1:0]       status_o,
  output logic [20:0]      data_address_o,
  output logic [20:0]      block_bytes_o
);
  import bha_pkg::*;

  logic [20:0] limit_q;
  logic        cmd_valid, cmd_pop;
  cmd_t        cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= 21'd1048576;
    else if (cfg_we_i) limit_q <= cfg_wdata_i;
  end

  bha_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .mode_i, .req_bytes_i, .address_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd));

  bha_back u_back (
    .clk_i, .rst_ni, .heap_limit_i(limit_q), .cmd_valid_i(cmd_valid),
    .cmd_pop_o(cmd_pop), .cmd_i(cmd), .valid_o, .stall_i, .status_o,
    .data_address_o, .block_bytes_o);
endmodule
`default_nettype wire

### sv/bha_ram.sv
// ----------------------------------------------------------------------------
// bha_ram: generic single-port-write, one-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module bha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### sv/bha_front.sv
// ----------------------------------------------------------------------------
// bha_front: input stage and command queue
// Rounds requests, flags trivial failures and buffers commands.
// ----------------------------------------------------------------------------
`default_nettype none
module bha_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      stall_o,
  input  wire logic [1:0]           mode_i,
  input  wire logic [20:0]          req_bytes_i,
  input  wire logic [20:0]          address_i,
  output logic                      cmd_valid_o,
  input  wire logic                 cmd_pop_i,
  output bha_pkg::cmd_t             cmd_o
);
  import bha_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  cmd_t            q_mem [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic [DataW:0]  rounded;
  cmd_t            cmd_in;
  logic            push;

  // Classify the incoming transaction; a request that rounds past 21 bits
  // can never fit nor be appended.
  always_comb begin
    rounded       = {1'b0, req_bytes_i} + (DataW+1)'(AlignBytes - 1);
    cmd_in.mode   = mode_e'(mode_i);
    cmd_in.size   = rounded[DataW-1:0] & ~DataW'(AlignBytes - 1);
    cmd_in.addr   = address_i;
    cmd_in.fail   = (mode_i == MODE_NONE) ||
                    (mode_i == MODE_ALLOC && (req_bytes_i == '0 || rounded[DataW]));
  end

  assign stall_o     = (cnt_q == (PtrW+1)'(QDepth));
  assign push        = valid_i && !stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= cmd_in;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (cmd_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(cmd_pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cnt_q != '0) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QDepth)) else $error("queue overfull");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !cmd_pop_i) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("lost push");
endmodule
`default_nettype wire

### sv/bha_back.sv
// ----------------------------------------------------------------------------
// bha_back: table engine
// Walks the block table one entry per cycle, updates it and emits results.
// ----------------------------------------------------------------------------
`default_nettype none
module bha_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [20:0]          heap_limit_i,
  input  wire logic                 cmd_valid_i,
  output logic                      cmd_pop_o,
  input  wire bha_pkg::cmd_t        cmd_i,
  output logic                      valid_o,
  input  wire logic                 stall_i,
  output logic [1:0]                status_o,
  output logic [20:0]               data_address_o,
  output logic [20:0]               block_bytes_o
);
  import bha_pkg::*;

  localparam int unsigned MetaW = DataW + 1;

  state_e  state_q, state_d;
  cmd_t    cmd_q;
  idx_t    i_q, i_d;
  cnt_t    count_q;
  word_t   brk_q;
  logic    best_v_q;
  idx_t    best_q;
  word_t   best_sz_q, best_off_q;
  status_e status_q;
  word_t   data_addr_q, bytes_q;

  // Table RAMs: offset, and {free, size} per entry.
  logic             off_we, meta_we;
  idx_t             waddr, raddr;
  logic [MetaW-1:0] meta_w, meta_r;
  word_t            off_r;

  bha_ram #(.Width(DataW), .Depth(MaxBlocks)) u_off (
    .clk_i, .we_i(off_we), .waddr_i(waddr), .wdata_i(brk_q), .raddr_i(raddr),
    .rdata_o(off_r));
  bha_ram #(.Width(MetaW), .Depth(MaxBlocks)) u_meta (
    .clk_i, .we_i(meta_we), .waddr_i(waddr), .wdata_i(meta_w), .raddr_i(raddr),
    .rdata_o(meta_r));

  // Compare logic on the entry read for i_q (scan) or the tail (pop).
  word_t            sz_r;
  logic             in_rng, last, hit, fits, take, better, upd, app_ok, tail_free;
  logic [DataW+3:0] s4, r5;
  logic [DataW+1:0] end_sum, limit;
  logic [DataW:0]   span;
  idx_t             tail;

  always_comb begin
    sz_r      = meta_r[DataW-1:0];
    in_rng    = cnt_t'(i_q) < count_q;
    last      = (cnt_t'(i_q) + cnt_t'(1)) >= count_q;
    hit       = in_rng &&
                (({1'b0, off_r} + (DataW+1)'(HeaderBytes)) == {1'b0, cmd_q.addr});
    fits      = in_rng && meta_r[DataW] && (sz_r >= cmd_q.size);
    s4        = {1'b0, sz_r, 2'b00};
    r5        = {1'b0, cmd_q.size, 2'b00} + (DataW+4)'(cmd_q.size);
    take      = fits && (s4 <= r5);
    better    = fits && (!best_v_q || sz_r < best_sz_q);
    upd       = (cmd_q.mode == MODE_ALLOC) ? (take || better) : hit;
    end_sum   = (DataW+2)'(brk_q) + (DataW+2)'(HeaderBytes) + (DataW+2)'(cmd_q.size);
    limit     = (heap_limit_i > DataW'(HeapBytes)) ? (DataW+2)'(HeapBytes)
                                                  : (DataW+2)'(heap_limit_i);
    app_ok    = (count_q < cnt_t'(MaxBlocks)) && (end_sum <= limit);
    tail      = idx_t'(count_q - cnt_t'(1));
    // the block just freed may be the tail before its write reaches the RAM
    tail_free = (count_q != '0) && (meta_r[DataW] || tail == best_q);
    span      = (DataW+1)'(HeaderBytes) + (DataW+1)'(sz_r);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    i_d     = '0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) state_d = cmd_i.fail ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        if (last || ((cmd_q.mode == MODE_ALLOC) ? take : hit)) state_d = S_COMMIT;
        else i_d = i_q + idx_t'(1);
      end
      S_COMMIT: state_d = (cmd_q.mode == MODE_FREE && best_v_q) ? S_POP : S_DONE;
      S_POP: begin
        if (!tail_free) state_d = S_DONE;
      end
      S_DONE: begin
        if (!stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Handshakes and table RAM control.
  always_comb begin
    cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
    valid_o   = (state_q == S_DONE);
    raddr     = i_d;
    off_we    = 1'b0;
    meta_we   = 1'b0;
    waddr     = best_q;
    meta_w    = {1'b0, best_sz_q};
    case (state_q)
      S_COMMIT: begin
        raddr = tail;
        if (cmd_q.mode == MODE_ALLOC) begin
          if (best_v_q) begin
            meta_we = 1'b1;
          end else if (app_ok) begin
            off_we  = 1'b1;
            meta_we = 1'b1;
            waddr   = idx_t'(count_q);
            meta_w  = {1'b0, cmd_q.size};
          end
        end else if (cmd_q.mode == MODE_FREE && best_v_q) begin
          meta_we = 1'b1;
          meta_w  = {1'b1, best_sz_q};
        end
      end
      S_POP: raddr = idx_t'(count_q - cnt_t'(2));
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Datapath, break pointer and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= '0;
      i_q         <= '0;
      count_q     <= '0;
      brk_q       <= '0;
      best_v_q    <= 1'b0;
      best_q      <= '0;
      best_sz_q   <= '0;
      best_off_q  <= '0;
      status_q    <= ST_OK;
      data_addr_q <= '0;
      bytes_q     <= '0;
    end else begin
      i_q <= i_d;
      case (state_q)
        S_IDLE: if (cmd_valid_i) begin
          cmd_q       <= cmd_i;
          best_v_q    <= 1'b0;
          status_q    <= (cmd_i.mode == MODE_ALLOC) ? ST_OOM : ST_ADDR;
          data_addr_q <= '0;
          bytes_q     <= '0;
        end
        S_SCAN: if (upd) begin
          best_v_q   <= 1'b1;
          best_q     <= i_q;
          best_sz_q  <= sz_r;
          best_off_q <= off_r;
        end
        S_COMMIT: begin
          if (cmd_q.mode == MODE_ALLOC) begin
            if (best_v_q) begin
              status_q    <= ST_OK;
              data_addr_q <= best_off_q + DataW'(HeaderBytes);
              bytes_q     <= best_sz_q;
            end else if (app_ok) begin
              status_q    <= ST_OK;
              data_addr_q <= brk_q + DataW'(HeaderBytes);
              bytes_q     <= cmd_q.size;
              brk_q       <= end_sum[DataW-1:0];
              count_q     <= count_q + cnt_t'(1);
            end
          end else if (best_v_q) begin
            status_q    <= ST_OK;
            data_addr_q <= cmd_q.addr;
            bytes_q     <= best_sz_q;
          end
        end
        // pop one free tail block per cycle
        S_POP: if (tail_free) begin
          brk_q   <= (span > (DataW+1)'(brk_q)) ? '0 : brk_q - span[DataW-1:0];
          count_q <= count_q - cnt_t'(1);
        end
        default: ;
      endcase
    end
  end

  assign status_o       = status_q;
  assign data_address_o = data_addr_q;
  assign block_bytes_o  = bytes_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(status_o) &&
      $stable(data_address_o) && $stable(block_bytes_o)))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(MaxBlocks)) else $error("block count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_q <= DataW'(HeapBytes)) else $error("break past heap end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> cmd_valid_i) else $error("pop without command");
endmodule
`default_nettype wire

### sim/tb_break_heap_allocator.sv
// ----------------------------------------------------------------------------
// tb_break_heap_allocator: self-checking bench for the break heap allocator
// Drives allocate/free/query transactions with random gaps and output stalls,
// predicts each result from a behavioral copy of the block table and checks
// every field in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_break_heap_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import bha_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [20:0] cfg_wdata_i = '0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [1:0]  mode_i = '0;
  logic [20:0] req_bytes_i = '0;
  logic [20:0] address_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [20:0] data_address_o;
  logic [20:0] block_bytes_o;

  break_heap_allocator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .valid_i, .stall_o,
    .mode_i, .req_bytes_i, .address_i, .valid_o, .stall_i,
    .status_o, .data_address_o, .block_bytes_o
  );

  typedef struct packed {
    status_e st;
    word_t   addr;
    word_t   bytes;
  } heap_reply_t;

  // Predicted heap state
  int unsigned mdl_limit;
  int unsigned mdl_off [MaxBlocks];
  int unsigned mdl_size [MaxBlocks];
  bit          mdl_free [MaxBlocks];
  int unsigned mdl_count;
  int unsigned mdl_brk;

  heap_reply_t pending_replies[$];
  int unsigned n_fail = 0;
  bit          burst_mode = 1'b0;

  initial forever #1 clk_i = ~clk_i;

  function automatic int find_entry(int unsigned a);
    for (int i = 0; i < mdl_count; i++)
      if (mdl_off[i] + HeaderBytes == a) return i;
    return -1;
  endfunction

  function automatic heap_reply_t heap_predict(mode_e m, int unsigned req, int unsigned a);
    heap_reply_t r;
    int unsigned sz, s, lim, e;
    int best, k;
    r = '{ST_OK, '0, '0};
    best = -1;
    case (m)
      MODE_ALLOC: begin
        if (req == 0) begin
          r.st = ST_OOM;
          return r;
        end
        sz = (req + AlignBytes - 1) & ~(AlignBytes - 1);
        for (int i = 0; i < mdl_count; i++) begin
          s = mdl_size[i];
          if (!mdl_free[i] || s < sz) continue;
          if (4 * s <= 5 * sz) begin
            best = i;
            break;
          end
          if (best < 0 || s < mdl_size[best]) best = i;
        end
        if (best >= 0) begin
          mdl_free[best] = 1'b0;
          r.addr = word_t'(mdl_off[best] + HeaderBytes);
          r.bytes = word_t'(mdl_size[best]);
          return r;
        end
        lim = (mdl_limit < HeapBytes) ? mdl_limit : HeapBytes;
        e = mdl_brk + HeaderBytes + sz;
        if (mdl_count >= MaxBlocks || e > lim) begin
          r.st = ST_OOM;
          return r;
        end
        mdl_off[mdl_count] = mdl_brk;
        mdl_size[mdl_count] = sz;
        mdl_free[mdl_count] = 1'b0;
        mdl_count++;
        r.addr = word_t'(mdl_brk + HeaderBytes);
        r.bytes = word_t'(sz);
        mdl_brk = e;
      end
      MODE_FREE: begin
        k = find_entry(a);
        if (k < 0) begin
          r.st = ST_ADDR;
          return r;
        end
        r.addr = word_t'(a);
        r.bytes = word_t'(mdl_size[k]);
        mdl_free[k] = 1'b1;
        // pop free tail blocks and pull the break back
        while (mdl_count > 0 && mdl_free[mdl_count-1]) begin
          s = HeaderBytes + mdl_size[mdl_count-1];
          mdl_brk = (s > mdl_brk) ? 0 : mdl_brk - s;
          mdl_count--;
        end
      end
      MODE_QUERY: begin
        k = find_entry(a);
        if (k < 0) begin
          r.st = ST_ADDR;
          return r;
        end
        r.addr = word_t'(a);
        r.bytes = word_t'(mdl_size[k]);
      end
      default: r.st = ST_ADDR;
    endcase
    return r;
  endfunction

  // Send one transaction and queue its expected result
  task automatic send_cmd(mode_e m, int unsigned req, int unsigned a);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    mode_i <= m;
    req_bytes_i <= req[20:0];
    address_i <= a[20:0];
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    pending_replies.push_back(heap_predict(m, req & 32'h1FFFFF, a & 32'h1FFFFF));
  endtask

  task automatic drain;
    valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (MaxBlocks + 8) @(posedge clk_i);
  endtask

  task automatic write_limit(int unsigned v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[20:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_limit = v & 32'h1FFFFF;
  endtask

  // Pick a live data address most of the time, else a near miss or junk
  function automatic int unsigned pick_addr();
    int unsigned c;
    c = $urandom_range(0, 9);
    if (mdl_count != 0 && c < 7) return mdl_off[$urandom_range(0, mdl_count-1)] + HeaderBytes;
    if (c < 9) return $urandom_range(0, 4096);
    return $urandom & 21'h1FFFFF;
  endfunction

  function automatic int unsigned pick_req();
    int unsigned c;
    c = $urandom_range(0, 19);
    if (c == 0) return $urandom & 21'h1FFFFF;
    if (c == 1) return 0;
    return $urandom_range(1, 600);
  endfunction

  // Output stall generator
  initial begin
    int unsigned n;
    forever begin
      n = $urandom_range(0, 13);
      if (burst_mode) n = 0;
      stall_i <= (n != 0);
      repeat (n) @(posedge clk_i);
      stall_i <= 1'b0;
      @(posedge clk_i);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    heap_reply_t x;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result status=%0d", status_o);
        n_fail++;
      end else begin
        x = pending_replies.pop_front();
        if (status_o !== x.st) begin
          $error("status exp %0d got %0d", x.st, status_o);
          n_fail++;
        end
        if (data_address_o !== x.addr) begin
          $error("data_address exp %0d got %0d", x.addr, data_address_o);
          n_fail++;
        end
        if (block_bytes_o !== x.bytes) begin
          $error("block_bytes exp %0d got %0d", x.bytes, block_bytes_o);
          n_fail++;
        end
      end
    end
  end

  task automatic test_directed;
    send_cmd(MODE_ALLOC, 0, 0);
    send_cmd(MODE_ALLOC, 1, 0);
    send_cmd(MODE_ALLOC, 100, 0);
    send_cmd(MODE_ALLOC, 16, 0);
    send_cmd(MODE_QUERY, 0, 24);
    send_cmd(MODE_QUERY, 0, 25);
    send_cmd(MODE_FREE, 0, 64);
    send_cmd(MODE_QUERY, 0, 64);
    send_cmd(MODE_ALLOC, 80, 0);
    send_cmd(MODE_FREE, 0, 64);
    send_cmd(MODE_ALLOC, 20, 0);
    send_cmd(MODE_FREE, 0, 64);
    send_cmd(MODE_FREE, 0, 64);
    send_cmd(MODE_FREE, 0, 152);
    send_cmd(MODE_NONE, 21'h1FFFFF, 21'h1FFFFF);
    send_cmd(MODE_ALLOC, 21'h1FFFFF, 0);
    send_cmd(MODE_ALLOC, 1048576 - 24, 0);
    send_cmd(MODE_FREE, 0, 21'h1FFFFF);
    send_cmd(MODE_FREE, 0, 24);
    send_cmd(MODE_FREE, 0, 24);
    // freeing the tail pops the run of free blocks directly below it
    send_cmd(MODE_FREE, 0, 200);
  endtask

  // Fill the table, try one allocation past its last entry, then release it
  task automatic test_table_full;
    for (int i = 0; i <= MaxBlocks; i++) send_cmd(MODE_ALLOC, 1, 0);
    for (int i = MaxBlocks - 1; i >= 0; i--) send_cmd(MODE_FREE, 0, i * 40 + HeaderBytes);
  endtask

  task automatic test_limits;
    write_limit(0);
    send_cmd(MODE_ALLOC, 1, 0);
    write_limit(200);
    repeat (6) send_cmd(MODE_ALLOC, 40, 0);
    write_limit(60);
    send_cmd(MODE_ALLOC, 8, 0);
    send_cmd(MODE_FREE, 0, 96);
    send_cmd(MODE_ALLOC, 8, 0);
    send_cmd(MODE_FREE, 0, 24);
    send_cmd(MODE_FREE, 0, 96);
    write_limit(21'h1FFFFF);
    send_cmd(MODE_ALLOC, 1048576 - 24, 0);
    send_cmd(MODE_FREE, 0, 24);
  endtask

  task automatic test_random(int unsigned n);
    int unsigned c;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 9);
      if (c < 5) send_cmd(MODE_ALLOC, pick_req(), $urandom & 21'h1FFFFF);
      else if (c < 8) send_cmd(MODE_FREE, 0, pick_addr());
      else if (c < 9) send_cmd(MODE_QUERY, 0, pick_addr());
      else send_cmd(mode_e'($urandom_range(0, 3)), $urandom, $urandom);
    end
  endtask

  initial begin
    mdl_limit = HeapBytes;
    mdl_count = 0;
    mdl_brk = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_limits();
    write_limit(4000);
    test_random(350);
    burst_mode = 1'b1;
    test_random(100);
    burst_mode = 1'b0;
    write_limit(HeapBytes);
    test_random(350);
    write_limit(1500);
    test_random(250);
    drain();
    if (n_fail == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
